>>> rtl/wildcard_byte_pattern_scan_core_macros.svh
// assertion macros for the wildcard byte pattern scan core
`ifndef WILDCARD_BYTE_PATTERN_SCAN_CORE_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define WBPS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wbps check failed: same-cycle implication");
`define WBPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wbps check failed: next-cycle implication");
`else
`define WBPS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define WBPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/wbps_pkg.sv
// types and constants of the wildcard byte pattern scan core
`timescale 1ns / 1ps
package wbps_pkg;

   localparam int MaxPattern = 256;
   localparam int PtrW       = $clog2(MaxPattern);
   localparam int LenW       = PtrW + 1;
   localparam int AddrW      = 32;
   localparam int ByteW      = 8;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_SCAN   = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      action_type       action;
      logic [ByteW-1:0] value;
      logic             care;
      logic             region_start;
      logic [AddrW-1:0] byte_address;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [AddrW-1:0] match_address;
      logic [LenW-1:0]  pattern_length;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic issue;
      logic finish;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic need_check;
      logic last_issue;
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/wildcard_byte_pattern_scan_core.sv
// top level of the wildcard byte pattern scan core
//
//  channel   ports                          direction
//  request   req_valid req_ready req_data   in   (action, value, care, region_start, address)
//  response  rsp_valid rsp_ready rsp_data   out  (found, match_address, length, overflow)
//
// append, clear, no-op, and a scan byte with no window test: idle straight to the response state
// scan byte with a window test: passes through the check and drain states, one pattern entry per
//    cycle through the single read port of the pattern and history memories
// reset is synchronous; no memory clearing pass is needed
// a finished item waits in the output register while the next item is taken;
//    the core stalls only when a second result is ready and the first is not taken
`timescale 1ns / 1ps
module wildcard_byte_pattern_scan_core import wbps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   wbps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wbps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/wbps_ctrl.sv
// controller state machine of the wildcard byte pattern scan core
`timescale 1ns / 1ps
module wbps_ctrl import wbps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.need_check ? ST_CHECK : ST_RESP;
            end
         end
         ST_CHECK: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

endmodule

>>> rtl/wbps_datapath.sv
// pattern store, byte history and window compare of the scan core
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scan_core_macros.svh"
module wbps_datapath import wbps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   logic [ByteW:0]   pat_mem [MaxPattern];
   logic [ByteW-1:0] hist_mem [MaxPattern];

   logic [LenW-1:0]  loaded_len_ff;
   logic [LenW-1:0]  bir_ff;
   logic             match_seen_ff;
   logic [AddrW-1:0] first_addr_ff;
   logic             overflow_ff;
   logic [PtrW-1:0]  head_ff;
   logic [PtrW-1:0]  base_ff;
   logic [PtrW-1:0]  k_ff;
   logic [AddrW-1:0] addr_ff;
   logic [ByteW:0]   pat_rd_ff;
   logic [ByteW-1:0] hist_rd_ff;
   logic             cmp_vld_ff;
   logic             mism_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [LenW-1:0]  bir_in;
   logic [LenW-1:0]  len_m1;
   logic [PtrW-1:0]  head_in;
   logic [PtrW-1:0]  base_in;
   logic             full;
   logic             is_scan;
   logic             is_clear;
   logic             cur_mism;
   logic             any_mism;
   rsp_type          rsp_in;

   always_comb begin
      if (req_data.region_start) begin
         bir_in = LenW'(1);
      end else if (bir_ff < LenW'(MaxPattern)) begin
         bir_in = bir_ff + LenW'(1);
      end else begin
         bir_in = bir_ff;
      end
   end

   assign len_m1   = loaded_len_ff - LenW'(1);
   assign head_in  = head_ff + PtrW'(1);
   assign base_in  = head_in - len_m1[PtrW-1:0];
   assign full     = (loaded_len_ff == LenW'(MaxPattern));
   assign is_scan  = (req_data.action == ACT_SCAN);
   assign is_clear = (req_data.action == ACT_CLEAR);
   assign cur_mism = pat_rd_ff[ByteW] && (pat_rd_ff[ByteW-1:0] != hist_rd_ff);
   assign any_mism = mism_ff || (cmp_vld_ff && cur_mism);

   assign status.need_check = is_scan && !match_seen_ff && (loaded_len_ff != '0)
                              && (bir_in >= loaded_len_ff);
   assign status.last_issue = ({1'b0, k_ff} == len_m1);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in.found          = match_seen_ff;
      rsp_in.match_address  = match_seen_ff ? first_addr_ff : '0;
      rsp_in.pattern_length = loaded_len_ff;
      rsp_in.overflow       = overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_len_ff <= '0;
         bir_ff        <= '0;
         match_seen_ff <= 1'b0;
         first_addr_ff <= '0;
         overflow_ff   <= 1'b0;
         head_ff       <= '0;
         cmp_vld_ff    <= 1'b0;
         mism_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            unique case (req_data.action)
               ACT_APPEND: begin
                  if (!full) begin
                     loaded_len_ff <= loaded_len_ff + LenW'(1);
                  end else begin
                     overflow_ff <= 1'b1;
                  end
               end
               ACT_SCAN: begin
                  bir_ff  <= bir_in;
                  head_ff <= head_in;
               end
               ACT_CLEAR: begin
                  loaded_len_ff <= '0;
                  bir_ff        <= '0;
                  match_seen_ff <= 1'b0;
                  first_addr_ff <= '0;
                  overflow_ff   <= 1'b0;
               end
               ACT_NONE: begin
               end
            endcase
         end
         if (cmd.finish && !any_mism) begin
            match_seen_ff <= 1'b1;
            first_addr_ff <= addr_ff - AddrW'(len_m1);
         end
         cmp_vld_ff <= cmd.issue;
         if (cmd.accept) begin
            mism_ff <= 1'b0;
         end else if (cmp_vld_ff && cur_mism) begin
            mism_ff <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff <= req_data.byte_address;
         base_ff <= base_in;
         k_ff    <= '0;
      end else if (cmd.issue) begin
         k_ff <= k_ff + PtrW'(1);
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // pattern store
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_data.action == ACT_APPEND) && !full) begin
         pat_mem[loaded_len_ff[PtrW-1:0]] <= {req_data.care, req_data.value};
      end
      if (cmd.issue) begin
         pat_rd_ff <= pat_mem[k_ff];
      end
   end

   // byte history, circular
   always_ff @(posedge clock) begin
      if (cmd.accept && is_scan) begin
         hist_mem[head_in] <= req_data.value;
      end
      if (cmd.issue) begin
         hist_rd_ff <= hist_mem[base_ff + k_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `WBPS_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.accept && is_clear, (loaded_len_ff == '0) && !match_seen_ff && !overflow_ff)
   `WBPS_ASSERT_NEXT(a_match_sticky, clock, reset, match_seen_ff && !(cmd.accept && is_clear), match_seen_ff && $stable(first_addr_ff))
   `WBPS_ASSERT_IMPL(a_len_bound, clock, reset, 1'b1, (loaded_len_ff <= LenW'(MaxPattern)) && (bir_ff <= LenW'(MaxPattern)))
   `WBPS_ASSERT_IMPL(a_no_rsp_overrun, clock, reset, cmd.load_rsp, !rsp_valid_ff || rsp_ready)

endmodule
